// ----- rtl/clpm_pkg.sv -----
// Shared types and constants of the circular list pool manager.
package clpm_pkg;

  // Index space of the link fields and the number of pool entries in use
  localparam int INDEX_SPACE = 128;
  localparam int IDX_W       = 7;
  localparam int DATA_W      = 32;
  localparam int POOL_SIZE   = 128;
  localparam int REACH       = (POOL_SIZE < INDEX_SPACE) ? POOL_SIZE : INDEX_SPACE;
  localparam int STEP_W      = $clog2(REACH + 1);

  // Free search groups the use flags by eight
  localparam int GRP_W     = 8;
  localparam int GRP_BIT_W = $clog2(GRP_W);
  localparam int NUM_GRP   = INDEX_SPACE / GRP_W;
  localparam int GRP_IDX_W = $clog2(NUM_GRP);

  typedef enum logic [1:0] {
    REQ_APPEND  = 2'd0,
    REQ_DELETE  = 2'd1,
    REQ_REVERSE = 2'd2,
    REQ_READ    = 2'd3
  } req_e;

  // Write ports of the node store
  typedef struct packed {
    logic                    next_we;
    logic [IDX_W-1:0]        next_addr;
    logic [IDX_W-1:0]        next_data;
    logic                    prev_we;
    logic [IDX_W-1:0]        prev_addr;
    logic [IDX_W-1:0]        prev_data;
    logic                    data_we;
    logic [IDX_W-1:0]        data_addr;
    logic [DATA_W-1:0]       data_val;
  } store_wr_t;

  // Update of the use flags
  typedef struct packed {
    logic             set;
    logic             clr;
    logic [IDX_W-1:0] idx;
  } use_upd_t;

endpackage

// ----- rtl/clpm_store.sv -----
// Node store: next links, prev links and data words, with registered read data.
module clpm_store
  import clpm_pkg::*;
(
  input  logic               clk_i,
  input  logic [IDX_W-1:0]   rd_addr_i,
  input  store_wr_t          wr_i,
  output logic [IDX_W-1:0]   rd_next_o,
  output logic [IDX_W-1:0]   rd_prev_o,
  output logic [DATA_W-1:0]  rd_data_o
);

  logic [IDX_W-1:0]  next_mem [INDEX_SPACE];
  logic [IDX_W-1:0]  prev_mem [INDEX_SPACE];
  logic [DATA_W-1:0] data_mem [INDEX_SPACE];

  // Next link memory
  always_ff @(posedge clk_i) begin
    if (wr_i.next_we) begin
      next_mem[wr_i.next_addr] <= wr_i.next_data;
    end
    rd_next_o <= next_mem[rd_addr_i];
  end

  // Prev link memory
  always_ff @(posedge clk_i) begin
    if (wr_i.prev_we) begin
      prev_mem[wr_i.prev_addr] <= wr_i.prev_data;
    end
    rd_prev_o <= prev_mem[rd_addr_i];
  end

  // Data word memory
  always_ff @(posedge clk_i) begin
    if (wr_i.data_we) begin
      data_mem[wr_i.data_addr] <= wr_i.data_val;
    end
    rd_data_o <= data_mem[rd_addr_i];
  end

endmodule

// ----- rtl/clpm_free_find.sv -----
// Use flags of the pool and a two-stage search for the lowest free entry.
module clpm_free_find
  import clpm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  use_upd_t         upd_i,
  output logic             found_o,
  output logic [IDX_W-1:0] free_idx_o
);

  logic [INDEX_SPACE-1:0] in_use_q;
  logic [INDEX_SPACE-1:0] avail;
  logic [NUM_GRP-1:0]     grp_free;
  logic [GRP_IDX_W-1:0]   grp_d, grp_q;
  logic                   any_d, any_q;
  logic [GRP_W-1:0]       grp_bits;
  logic [GRP_BIT_W-1:0]   bit_sel;

  // Use flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
    end else if (upd_i.set) begin
      in_use_q[upd_i.idx] <= 1'b1;
    end else if (upd_i.clr) begin
      in_use_q[upd_i.idx] <= 1'b0;
    end
  end

  // Entries beyond the reachable range never count as free
  always_comb begin
    for (int i = 0; i < INDEX_SPACE; i++) begin
      avail[i] = ~in_use_q[i] && (i < REACH);
    end
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_free[g] = |avail[g*GRP_W +: GRP_W];
    end
  end

  // Stage one: lowest group with a free entry
  always_comb begin
    grp_d = '0;
    any_d = 1'b0;
    for (int g = NUM_GRP - 1; g >= 0; g--) begin
      if (grp_free[g]) begin
        grp_d = GRP_IDX_W'(g);
        any_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q <= '0;
      any_q <= 1'b0;
    end else begin
      grp_q <= grp_d;
      any_q <= any_d;
    end
  end

  // Stage two: lowest free entry inside the chosen group
  always_comb begin
    grp_bits = avail[grp_q*GRP_W +: GRP_W];
    bit_sel  = '0;
    for (int b = GRP_W - 1; b >= 0; b--) begin
      if (grp_bits[b]) begin
        bit_sel = GRP_BIT_W'(b);
      end
    end
  end

  assign found_o    = any_q & (|grp_bits);
  assign free_idx_o = {grp_q, bit_sel};

endmodule

// ----- rtl/circular_list_pool_manager.sv -----
// Top level: request sequencer of the circular list pool manager.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. Its
//   single result appears on the result ports for exactly one cycle, marked
//   by done_o; the receiver cannot stall, so it must take it then.
//   busy is high from the cycle after acceptance up to and including the
//   last work cycle; the result strobe cycle overlaps the next acceptance.
// Path (acceptance to done_o):
//   Every request reads the node store in S_A and decides in S_B. A read,
//   an append to an empty list, a delete of a one-node list, an empty list,
//   an out-of-range head index and an append to a full pool end in S_B;
//   an append to a non-empty list and a delete from a longer list write in S_C;
//   a reverse passes S_A and S_B once per node of the list. Each link step is
//   a registered memory read followed by a compare and write back.
// Reset: all pool entries are marked free at once; links and data words are
//   undefined until written by an append. No clearing pass is needed.
// A full pool makes an append return status 1 and change nothing.
module circular_list_pool_manager
  import clpm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               req_type_i,
  input  logic [IDX_W-1:0]         head_index_i,
  input  logic                     head_present_i,
  input  logic [IDX_W-1:0]         node_index_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     done_o,
  output logic [IDX_W-1:0]         result_head_o,
  output logic                     result_head_present_o,
  output logic                     status_o,
  output logic signed [DATA_W-1:0] node_value_o,
  output logic [IDX_W-1:0]         node_next_o,
  output logic [IDX_W-1:0]         node_prev_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_A,
    S_B,
    S_C
  } state_e;

  state_e             state_q;
  req_e               req_q;
  logic [IDX_W-1:0]   head_q, node_q, cur_q, free_q, last_q;
  logic               present_q;
  logic [DATA_W-1:0]  val_q;
  logic [STEP_W-1:0]  steps_q;

  logic               done_q, res_pres_q, status_q;
  logic [IDX_W-1:0]   res_head_q, nnext_q, nprev_q;
  logic [DATA_W-1:0]  nval_q;

  logic [IDX_W-1:0]   rd_addr, rd_next, rd_prev;
  logic [DATA_W-1:0]  rd_data;
  store_wr_t          wr;
  use_upd_t           upd;
  logic               found;
  logic [IDX_W-1:0]   free_idx;

  logic               head_bad, node_ok, list_ok, single, walk_on;

  // Range and shape checks on the latched request
  assign head_bad = present_q && (int'(head_q) >= REACH);
  assign node_ok  = int'(node_q) < REACH;
  assign list_ok  = present_q && !head_bad;
  assign single   = (rd_next == head_q);
  assign walk_on  = (rd_next != head_q) && (steps_q < STEP_W'(REACH));

  // Second read of a delete goes to the named node
  assign rd_addr = (state_q == S_B) ? node_q : cur_q;

  clpm_store u_store (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .wr_i      (wr),
    .rd_next_o (rd_next),
    .rd_prev_o (rd_prev),
    .rd_data_o (rd_data)
  );

  clpm_free_find u_free (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (upd),
    .found_o    (found),
    .free_idx_o (free_idx)
  );

  // Store writes and use flag updates
  always_comb begin
    wr  = '0;
    upd = '0;
    case (state_q)
      S_B: begin
        case (req_q)
          REQ_APPEND: begin
            if (!head_bad && found) begin
              wr.data_we   = 1'b1;
              wr.data_addr = free_idx;
              wr.data_val  = val_q;
              upd.set      = 1'b1;
              upd.idx      = free_idx;
              wr.next_we   = 1'b1;
              wr.prev_we   = 1'b1;
              wr.next_data = free_idx;
              wr.prev_data = free_idx;
              if (!present_q) begin
                wr.next_addr = free_idx;
                wr.prev_addr = free_idx;
              end else begin
                // old tail points forward to the new node, head back to it
                wr.next_addr = rd_prev;
                wr.prev_addr = head_q;
              end
            end
          end
          REQ_DELETE: begin
            if (list_ok && node_ok && single) begin
              upd.clr = 1'b1;
              upd.idx = node_q;
            end
          end
          REQ_REVERSE: begin
            if (list_ok) begin
              wr.next_we   = 1'b1;
              wr.next_addr = cur_q;
              wr.next_data = rd_prev;
              wr.prev_we   = 1'b1;
              wr.prev_addr = cur_q;
              wr.prev_data = rd_next;
            end
          end
          default: ;
        endcase
      end
      S_C: begin
        if (req_q == REQ_APPEND) begin
          wr.next_we   = 1'b1;
          wr.next_addr = free_q;
          wr.next_data = head_q;
          wr.prev_we   = 1'b1;
          wr.prev_addr = free_q;
          wr.prev_data = last_q;
        end else begin
          // unlink: prev node skips forward, next node skips back
          wr.next_we   = 1'b1;
          wr.next_addr = rd_prev;
          wr.next_data = rd_next;
          wr.prev_we   = 1'b1;
          wr.prev_addr = rd_next;
          wr.prev_data = rd_prev;
          upd.clr      = 1'b1;
          upd.idx      = node_q;
        end
      end
      default: ;
    endcase
  end

  // Sequencer with request and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      req_q      <= REQ_APPEND;
      head_q     <= '0;
      node_q     <= '0;
      cur_q      <= '0;
      free_q     <= '0;
      last_q     <= '0;
      present_q  <= 1'b0;
      val_q      <= '0;
      steps_q    <= '0;
      done_q     <= 1'b0;
      res_pres_q <= 1'b0;
      status_q   <= 1'b0;
      res_head_q <= '0;
      nnext_q    <= '0;
      nprev_q    <= '0;
      nval_q     <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            req_q      <= req_e'(req_type_i);
            head_q     <= head_index_i;
            node_q     <= node_index_i;
            present_q  <= head_present_i;
            val_q      <= value_i;
            cur_q      <= (req_e'(req_type_i) == REQ_READ) ? node_index_i : head_index_i;
            steps_q    <= '0;
            res_head_q <= head_index_i;
            res_pres_q <= head_present_i;
            status_q   <= 1'b0;
            nval_q     <= '0;
            nnext_q    <= '0;
            nprev_q    <= '0;
            state_q    <= S_A;
          end
        end
        S_A: begin
          state_q <= S_B;
        end
        S_B: begin
          case (req_q)
            REQ_APPEND: begin
              if (head_bad) begin
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end else if (!found) begin
                status_q <= 1'b1;
                done_q   <= 1'b1;
                state_q  <= S_IDLE;
              end else if (!present_q) begin
                res_head_q <= free_idx;
                res_pres_q <= 1'b1;
                done_q     <= 1'b1;
                state_q    <= S_IDLE;
              end else begin
                free_q  <= free_idx;
                last_q  <= rd_prev;
                state_q <= S_C;
              end
            end
            REQ_DELETE: begin
              if (!(list_ok && node_ok)) begin
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end else if (single) begin
                res_pres_q <= 1'b0;
                done_q     <= 1'b1;
                state_q    <= S_IDLE;
              end else begin
                state_q <= S_C;
              end
            end
            REQ_REVERSE: begin
              if (!list_ok) begin
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end else if (walk_on) begin
                // old next becomes the prev link, walk on along it
                cur_q   <= rd_next;
                steps_q <= steps_q + 1'b1;
                state_q <= S_A;
              end else begin
                res_head_q <= cur_q;
                done_q     <= 1'b1;
                state_q    <= S_IDLE;
              end
            end
            default: begin
              if (node_ok && !head_bad) begin
                nval_q  <= rd_data;
                nnext_q <= rd_next;
                nprev_q <= rd_prev;
              end
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          endcase
        end
        S_C: begin
          if (req_q == REQ_DELETE && head_q == node_q) begin
            res_head_q <= rd_next;
          end
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy                  = (state_q != S_IDLE);
  assign done_o                = done_q;
  assign result_head_o         = res_pres_q ? res_head_q : '0;
  assign result_head_present_o = res_pres_q;
  assign status_o              = status_q;
  assign node_value_o          = nval_q;
  assign node_next_o           = nnext_q;
  assign node_prev_o           = nprev_q;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Testbench of circular_list_pool_manager: list operations checked against a pool model.
module tb
  import clpm_pkg::*;
();

  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 10;
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PRINTS    = 100;

  // One request and the result it yields
  typedef struct packed {
    req_e                     op;
    logic [IDX_W-1:0]         head;
    logic                     present;
    logic [IDX_W-1:0]         node;
    logic signed [DATA_W-1:0] value;
  } list_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]         head;
    logic                     present;
    logic                     full;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         next;
    logic [IDX_W-1:0]         prev;
  } list_rsp_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [1:0]               req_type_i;
  logic [IDX_W-1:0]         head_index_i;
  logic                     head_present_i;
  logic [IDX_W-1:0]         node_index_i;
  logic signed [DATA_W-1:0] value_i;
  logic                     done_o;
  logic [IDX_W-1:0]         result_head_o;
  logic                     result_head_present_o;
  logic                     status_o;
  logic signed [DATA_W-1:0] node_value_o;
  logic [IDX_W-1:0]         node_next_o;
  logic [IDX_W-1:0]         node_prev_o;

  circular_list_pool_manager i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .start                 (start),
    .busy                  (busy),
    .req_type_i            (req_type_i),
    .head_index_i          (head_index_i),
    .head_present_i        (head_present_i),
    .node_index_i          (node_index_i),
    .value_i               (value_i),
    .done_o                (done_o),
    .result_head_o         (result_head_o),
    .result_head_present_o (result_head_present_o),
    .status_o              (status_o),
    .node_value_o          (node_value_o),
    .node_next_o           (node_next_o),
    .node_prev_o           (node_prev_o)
  );

  // Pool model: use flags, data words and links
  logic              pool_used    [INDEX_SPACE];
  logic              pool_written [INDEX_SPACE];
  logic [DATA_W-1:0] pool_word    [INDEX_SPACE];
  logic [IDX_W-1:0]  pool_next    [INDEX_SPACE];
  logic [IDX_W-1:0]  pool_prev    [INDEX_SPACE];
  int                written_idx  [$];   // entries that ever held a node

  list_rsp_t pending_rsp [$];   // results still owed by the block
  int        list_heads  [$];   // heads of the lists the stimulus works on
  int        error_count;
  int        cycle_count;
  bit        idle_on;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  function automatic void swap_links(input int idx);
    logic [IDX_W-1:0] tmp;
    tmp            = pool_prev[idx];
    pool_prev[idx] = pool_next[idx];
    pool_next[idx] = tmp;
  endfunction

  // Applies one request to the pool and returns the result it must give
  function automatic list_rsp_t list_op_outcome(input list_req_t req);
    list_rsp_t rsp;
    int        h, n, p, nx, cur, steps, free_idx;
    bit        head_bad;
    h        = req.head;
    n        = req.node;
    head_bad = req.present && (h >= REACH);
    rsp          = '0;
    rsp.head     = req.head;
    rsp.present  = req.present;
    case (req.op)
      REQ_APPEND: if (!head_bad) begin
        free_idx = -1;
        for (int i = 0; i < REACH; i++) begin
          if (!pool_used[i]) begin
            free_idx = i;
            break;
          end
        end
        if (free_idx < 0) begin
          rsp.full = 1'b1;
        end else begin
          pool_used[free_idx] = 1'b1;
          if (!pool_written[free_idx]) begin
            pool_written[free_idx] = 1'b1;
            written_idx.push_back(free_idx);
          end
          pool_word[free_idx] = req.value;
          if (!req.present) begin
            pool_next[free_idx] = IDX_W'(free_idx);
            pool_prev[free_idx] = IDX_W'(free_idx);
            rsp.head            = IDX_W'(free_idx);
            rsp.present         = 1'b1;
          end else begin
            // link in just before the head
            p                   = pool_prev[h];
            pool_next[p]        = IDX_W'(free_idx);
            pool_prev[h]        = IDX_W'(free_idx);
            pool_prev[free_idx] = IDX_W'(p);
            pool_next[free_idx] = IDX_W'(h);
          end
        end
      end
      REQ_DELETE: if (req.present && !head_bad && n < REACH) begin
        if (pool_next[h] == h) begin
          pool_used[n] = 1'b0;
          rsp.present  = 1'b0;
        end else begin
          p            = pool_prev[n];
          nx           = pool_next[n];
          pool_next[p] = IDX_W'(nx);
          pool_prev[nx] = IDX_W'(p);
          pool_used[n] = 1'b0;
          if (h == n) rsp.head = IDX_W'(nx);
        end
      end
      REQ_REVERSE: if (req.present && !head_bad) begin
        // walk is bounded so a broken ring still ends
        cur   = h;
        steps = 0;
        while (pool_next[cur] != h && steps < REACH) begin
          swap_links(cur);
          cur = pool_prev[cur];
          steps++;
        end
        swap_links(cur);
        rsp.head = IDX_W'(cur);
      end
      REQ_READ: if (n < REACH && !head_bad) begin
        rsp.value = pool_word[n];
        rsp.next  = pool_next[n];
        rsp.prev  = pool_prev[n];
      end
      default: ;
    endcase
    if (!rsp.present) rsp.head = '0;
    return rsp;
  endfunction

  function automatic list_req_t make_req(input req_e op, input int head, input bit present,
                                         input int node, input logic [DATA_W-1:0] value);
    list_req_t req;
    req.op      = op;
    req.head    = IDX_W'(head);
    req.present = present;
    req.node    = IDX_W'(node);
    req.value   = value;
    return req;
  endfunction

  function automatic int pick_written();
    return written_idx[$urandom_range(0, written_idx.size() - 1)];
  endfunction

  // Random node of the ring that starts at head
  function automatic int random_member(input int head);
    int len, cur, pick;
    len = 1;
    cur = pool_next[head];
    while (cur != head && len < REACH) begin
      cur = pool_next[cur];
      len++;
    end
    pick = $urandom_range(0, len - 1);
    cur  = head;
    repeat (pick) cur = pool_next[cur];
    return cur;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("[%0t] ERROR: %s", $time, what);
  endtask

  // Drives one transaction, holds it until taken, then maybe idles.
  // Called and returns at a falling edge; start stays high for a following item.
  task automatic issue_request(input list_req_t req, output list_rsp_t rsp);
    start          <= 1'b1;
    req_type_i     <= req.op;
    head_index_i   <= req.head;
    head_present_i <= req.present;
    node_index_i   <= req.node;
    value_i        <= req.value;
    do @(posedge clk_i); while (busy !== 1'b0);
    rsp = list_op_outcome(req);
    pending_rsp.push_back(rsp);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk_i); while (pending_rsp.size() != 0);
  endtask

  // Well-formed operation on a tracked list; grow_pct biases toward appends
  task automatic send_list_op(input int grow_pct, output bit was_full);
    list_req_t req;
    list_rsp_t rsp;
    int        k, h, roll;
    k    = -1;
    roll = $urandom_range(0, 99);
    if (list_heads.size() == 0 || (roll < grow_pct && $urandom_range(0, 7) == 0)) begin
      // open a new list; head and node are don't-care
      req = make_req(REQ_APPEND, $urandom_range(0, 127), 1'b0, $urandom_range(0, 127),
                     $urandom);
    end else begin
      k = $urandom_range(0, list_heads.size() - 1);
      h = list_heads[k];
      if (roll < grow_pct) begin
        req = make_req(REQ_APPEND, h, 1'b1, $urandom_range(0, 127), $urandom);
      end else begin
        case ($urandom_range(0, 3))
          0, 1: req = make_req(REQ_DELETE, h, 1'b1, random_member(h), $urandom);
          2: req = make_req(REQ_REVERSE, h, 1'b1, $urandom_range(0, 127), $urandom);
          default: req = make_req(REQ_READ, h, 1'b1,
                                  ($urandom_range(0, 3) == 0) ? pick_written() : random_member(h),
                                  $urandom);
        endcase
      end
    end
    issue_request(req, rsp);
    was_full = rsp.full;
    if (k < 0) begin
      if (rsp.present) list_heads.push_back(rsp.head);
    end else if (!rsp.present) begin
      list_heads.delete(k);
    end else begin
      list_heads[k] = rsp.head;
    end
  endtask

  // Arbitrary request; only entries that were written are ever dereferenced
  task automatic send_noise();
    list_req_t req;
    list_rsp_t rsp;
    req = make_req(req_e'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom_range(0, 1),
                   $urandom_range(0, 127), $urandom);
    if (written_idx.size() == 0) begin
      req.present = 1'b0;
      if (req.op == REQ_READ) req.op = REQ_APPEND;
    end else begin
      if (req.present) req.head = IDX_W'(pick_written());
      if (req.op == REQ_READ || req.op == REQ_DELETE) req.node = IDX_W'(pick_written());
    end
    issue_request(req, rsp);
  endtask

  // Empty lists, value extremes, one-node cases, reverse and reads
  task automatic test_directed_ops();
    list_rsp_t rsp;
    int        hd, solo;
    idle_on = 1'b1;
    issue_request(make_req(REQ_DELETE, 5, 1'b0, 9, '0), rsp);
    issue_request(make_req(REQ_REVERSE, 127, 1'b0, 127, '1), rsp);
    issue_request(make_req(REQ_APPEND, 127, 1'b0, 0, 32'h8000_0000), rsp);
    hd = rsp.head;
    issue_request(make_req(REQ_READ, hd, 1'b1, hd, '0), rsp);
    issue_request(make_req(REQ_REVERSE, hd, 1'b1, 0, '0), rsp);
    hd = rsp.head;
    issue_request(make_req(REQ_APPEND, hd, 1'b1, 127, 32'h7fff_ffff), rsp);
    issue_request(make_req(REQ_APPEND, hd, 1'b1, 0, '0), rsp);
    issue_request(make_req(REQ_APPEND, hd, 1'b1, 0, '1), rsp);
    for (int i = 0; i < 4; i++) issue_request(make_req(REQ_READ, hd, 1'b1, i, '0), rsp);
    issue_request(make_req(REQ_REVERSE, hd, 1'b1, 0, '0), rsp);
    hd = rsp.head;
    issue_request(make_req(REQ_READ, hd, 1'b1, pool_next[hd], '0), rsp);
    // middle node, then the head itself
    issue_request(make_req(REQ_DELETE, hd, 1'b1, pool_next[pool_next[hd]], '0), rsp);
    issue_request(make_req(REQ_DELETE, hd, 1'b1, hd, '0), rsp);
    hd = rsp.head;
    issue_request(make_req(REQ_APPEND, 0, 1'b0, 0, 32'h5555_5555), rsp);
    solo = rsp.head;
    issue_request(make_req(REQ_DELETE, solo, 1'b1, solo, '0), rsp);
    // freed entry still holds its old contents
    issue_request(make_req(REQ_READ, 127, 1'b0, solo, '0), rsp);
    issue_request(make_req(REQ_APPEND, hd, 1'b1, 0, 32'haaaa_aaaa), rsp);
    issue_request(make_req(REQ_REVERSE, hd, 1'b1, 0, '0), rsp);
    hd = rsp.head;
    issue_request(make_req(REQ_READ, hd, 1'b1, hd, '0), rsp);
    list_heads.push_back(hd);
  endtask

  // Fill the pool until appends are refused, then shrink it again
  task automatic test_pool_exhaustion();
    bit full;
    int full_count, n;
    full_count = 0;
    n          = 0;
    idle_on    = 1'b1;
    while (full_count < 4 && n < 600) begin
      send_list_op(90, full);
      if (full) full_count++;
      n++;
    end
    repeat (150) send_list_op(15, full);
    wait_drained();
  endtask

  // Mixed traffic with some noise, idle stretches switched on and off
  task automatic test_random_traffic();
    bit full;
    int grow;
    grow = 50;
    for (int i = 0; i < 750; i++) begin
      if (i % 50 == 0) begin
        idle_on = ($urandom_range(0, 2) != 0);
        grow    = $urandom_range(30, 70);
      end
      if (i % 250 == 249) wait_drained();
      if ($urandom_range(0, 15) == 0) send_noise();
      else send_list_op(grow, full);
    end
  endtask

  // Requests back to back with no idling
  task automatic test_back_to_back();
    bit full;
    idle_on = 1'b0;
    repeat (80) send_list_op(50, full);
  endtask

  // Result check: one expectation per strobe, oldest first
  always @(posedge clk_i) begin
    list_rsp_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        want = pending_rsp.pop_front();
        if (result_head_o !== want.head)
          report_mismatch($sformatf("result_head_o %0d, expected %0d",
                                    result_head_o, want.head));
        if (result_head_present_o !== want.present)
          report_mismatch($sformatf("result_head_present_o %b, expected %b",
                                    result_head_present_o, want.present));
        if (status_o !== want.full)
          report_mismatch($sformatf("status_o %b, expected %b", status_o, want.full));
        if (node_value_o !== want.value)
          report_mismatch($sformatf("node_value_o %h, expected %h", node_value_o, want.value));
        if (node_next_o !== want.next)
          report_mismatch($sformatf("node_next_o %0d, expected %0d", node_next_o, want.next));
        if (node_prev_o !== want.prev)
          report_mismatch($sformatf("node_prev_o %0d, expected %0d", node_prev_o, want.prev));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_rsp.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Sequence of tests
  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    req_type_i     = REQ_APPEND;
    head_index_i   = '0;
    head_present_i = 1'b0;
    node_index_i   = '0;
    value_i        = '0;
    error_count    = 0;
    cycle_count    = 0;
    idle_on        = 1'b0;
    for (int i = 0; i < INDEX_SPACE; i++) begin
      pool_used[i]    = 1'b0;
      pool_written[i] = 1'b0;
      pool_word[i]    = '0;
      pool_next[i]    = '0;
      pool_prev[i]    = '0;
    end
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_ops();
    test_pool_exhaustion();
    test_random_traffic();
    test_back_to_back();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/clpm_pkg.sv
rtl/clpm_store.sv
rtl/clpm_free_find.sv
rtl/circular_list_pool_manager.sv
bench/tb.sv
